@@ design/ccs_pkg.sv @@
// Shared types, constants and the quarter-round helper for the ChaCha20 stream cipher.
package ccs_pkg;

  // One keystream block: sixteen 32-bit words, byte p at bits [8p+7:8p].
  localparam int BLOCK_W = 512;

  // Keystream blocks held between the generator and the byte path.
  localparam int KSQ_DEPTH = 2;
  localparam int KSQ_PTR_W = $clog2(KSQ_DEPTH);
  localparam int KSQ_CNT_W = $clog2(KSQ_DEPTH + 1);

  // Block counter value after reset.
  localparam logic [31:0] CTR_RESET = 32'd1;

  // The "expand 32-byte k" constant words.
  localparam logic [31:0] SIGMA [4] = '{
    32'h6170_7865, 32'h3320_646e, 32'h7962_2d32, 32'h6b20_6574
  };

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KEY_01    = 3'd0,
    REG_KEY_23    = 3'd1,
    REG_KEY_45    = 3'd2,
    REG_KEY_67    = 3'd3,
    REG_NONCE_01  = 3'd4,
    REG_NONCE_2   = 3'd5,
    REG_INIT_CTR  = 3'd6
  } cfg_reg_t;

  // Status of the keystream queue as seen by its producer and consumer.
  typedef struct packed {
    logic full;
    logic empty;
  } ksq_stat_t;

  // The four words one quarter round works on.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } qr_lane_t;

  // Half of a quarter round: rotations 16/12 in the first half, 8/7 in the second.
  function automatic qr_lane_t qr_half(input qr_lane_t v, input logic second);
    qr_lane_t    r;
    logic [31:0] t;
    r   = v;
    r.a = v.a + v.b;
    t   = v.d ^ r.a;
    r.d = second ? {t[23:0], t[31:24]} : {t[15:0], t[31:16]};
    r.c = v.c + r.d;
    t   = v.b ^ r.c;
    r.b = second ? {t[24:0], t[31:25]} : {t[19:0], t[31:20]};
    return r;
  endfunction

endpackage

@@ design/ccs_if.sv @@
// Valid/ready stream interfaces for message bytes in and cipher bytes out.
interface ccs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ccs_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;

  modport source (output valid, output out_byte, input ready);
  modport sink   (input valid, input out_byte, output ready);
endinterface

@@ design/ccs_keygen.sv @@
// Keystream block generator: iterates half quarter rounds and adds the input state back.
module ccs_keygen import ccs_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  logic [31:0]        ctr_load,
  input  logic [255:0]       key,
  input  logic [95:0]        nonce,
  input  ksq_stat_t          q_stat,
  output logic               push_en,
  output logic [BLOCK_W-1:0] push_data
);

  // Four steps per double round: column first/second half, diagonal first/second half.
  localparam int STEPS  = DOUBLE_ROUNDS * 4;
  localparam int STEP_W = $clog2(STEPS);

  typedef enum logic [2:0] {
    KG_IDLE = 3'b001,
    KG_RUN  = 3'b010,
    KG_DONE = 3'b100
  } kg_state_t;

  kg_state_t         state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [31:0]       ctr_r, ctr_nxt;
  logic [31:0]       x_r [16];
  logic [31:0]       x_nxt [16];
  logic [31:0]       x_rnd [16];
  logic [31:0]       init_w [16];
  qr_lane_t          lane_in [4];
  qr_lane_t          lane_out [4];
  logic              half;
  logic              diag;

  assign half = step_r[0];
  assign diag = step_r[1];

  // Input state: constants, key, block counter, nonce.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init_w[i] = SIGMA[i];
    end
    for (int i = 0; i < 8; i++) begin
      init_w[4 + i] = key[32*i +: 32];
    end
    init_w[12] = ctr_r;
    for (int i = 0; i < 3; i++) begin
      init_w[13 + i] = nonce[32*i +: 32];
    end
  end

  // Four quarter-round lanes, routed as columns or diagonals.
  always_comb begin
    x_rnd = x_r;
    for (int j = 0; j < 4; j++) begin
      lane_in[j].a = x_r[j];
      lane_in[j].b = diag ? x_r[4 + ((j + 1) % 4)]  : x_r[4 + j];
      lane_in[j].c = diag ? x_r[8 + ((j + 2) % 4)]  : x_r[8 + j];
      lane_in[j].d = diag ? x_r[12 + ((j + 3) % 4)] : x_r[12 + j];
      lane_out[j]  = qr_half(lane_in[j], half);
    end
    for (int j = 0; j < 4; j++) begin
      x_rnd[j] = lane_out[j].a;
      if (diag) begin
        x_rnd[4 + ((j + 1) % 4)]  = lane_out[j].b;
        x_rnd[8 + ((j + 2) % 4)]  = lane_out[j].c;
        x_rnd[12 + ((j + 3) % 4)] = lane_out[j].d;
      end else begin
        x_rnd[4 + j]  = lane_out[j].b;
        x_rnd[8 + j]  = lane_out[j].c;
        x_rnd[12 + j] = lane_out[j].d;
      end
    end
  end

  // Feed-forward addition, words packed little-endian.
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      push_data[32*i +: 32] = x_r[i] + init_w[i];
    end
  end

  // Sequencer: start when the queue has room, run all steps, then push.
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    ctr_nxt   = ctr_r;
    x_nxt     = x_r;
    push_en   = 1'b0;
    unique case (state_r)
      KG_IDLE: begin
        if (!q_stat.full) begin
          x_nxt     = init_w;
          step_nxt  = '0;
          state_nxt = KG_RUN;
        end
      end
      KG_RUN: begin
        x_nxt    = x_rnd;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(STEPS - 1)) begin
          state_nxt = KG_DONE;
        end
      end
      KG_DONE: begin
        push_en   = 1'b1;
        ctr_nxt   = ctr_r + 32'd1;
        state_nxt = KG_IDLE;
      end
      default: begin
        state_nxt = KG_IDLE;
      end
    endcase
    // A configuration write abandons the block in flight.
    if (restart) begin
      push_en   = 1'b0;
      ctr_nxt   = ctr_load;
      state_nxt = KG_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= KG_IDLE;
      step_r  <= '0;
      ctr_r   <= CTR_RESET;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

  // Working state carries no reset.
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
  end

endmodule

@@ design/ccs_ksq.sv @@
// Small FIFO of finished keystream blocks between the generator and the byte path.
module ccs_ksq import ccs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               flush,
  input  logic               push_en,
  input  logic [BLOCK_W-1:0] push_data,
  input  logic               pop,
  output ksq_stat_t          q_stat,
  output logic [BLOCK_W-1:0] head_data
);

  logic [BLOCK_W-1:0]   mem [KSQ_DEPTH];
  logic [KSQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [KSQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [KSQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 do_push;
  logic                 do_pop;

  assign q_stat.full  = (cnt_r == KSQ_CNT_W'(KSQ_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push_en && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_data    = mem[rd_ptr_r];

  // Pointer and fill count update; a flush drops every stored block.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == KSQ_PTR_W'(KSQ_DEPTH - 1)) ? '0 : wr_ptr_r + KSQ_PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == KSQ_PTR_W'(KSQ_DEPTH - 1)) ? '0 : rd_ptr_r + KSQ_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + KSQ_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - KSQ_CNT_W'(1);
    end
    if (flush) begin
      wr_ptr_nxt = '0;
      rd_ptr_nxt = '0;
      cnt_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Block storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ design/ccs_front.sv @@
// Byte path: accepts message bytes, XORs them with the head keystream block, registers the result.
module ccs_front import ccs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               restart,
  input  ksq_stat_t          q_stat,
  input  logic [BLOCK_W-1:0] head_data,
  output logic               pop,
  ccs_in_if.sink             in_if,
  ccs_out_if.source          out_if
);

  logic [5:0] pos_r, pos_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       accept;
  logic [7:0] ks_byte;

  // Take a request when a block is ready and the output register is free or draining.
  assign in_if.ready = !q_stat.empty && (!ov_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;
  assign ks_byte     = head_data[{pos_r, 3'b000} +: 8];
  assign pop         = accept && (pos_r == 6'd63);

  assign out_if.valid    = ov_r;
  assign out_if.out_byte = ob_r;

  always_comb begin
    pos_nxt = pos_r;
    ov_nxt  = ov_r;
    ob_nxt  = ob_r;
    if (out_if.ready) begin
      ov_nxt = 1'b0;
    end
    if (accept) begin
      ov_nxt  = 1'b1;
      ob_nxt  = in_if.data_byte ^ ks_byte;
      pos_nxt = pos_r + 6'd1;
    end
    if (restart) begin
      pos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      ov_r  <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r <= ob_nxt;
  end

endmodule

@@ design/chacha20_stream_cipher_top.sv @@
// ChaCha20 stream cipher top level: configuration registers and the generator, queue and byte path.
//
// Each request carries one message byte and yields that byte XORed with the next
// ChaCha20 keystream byte (32-bit block counter, 96-bit nonce). The byte path takes
// one request per cycle and keeps that rate as long as a keystream block is queued and
// the results are taken; the output register lets a new request in while its held
// result is being taken. Keystream blocks come from a generator that runs one half
// quarter round over all four lanes per cycle and, at ten double rounds, finishes a
// block before the byte path uses up its 64 bytes; a two-block queue holds the next
// block ready. After reset and after every write to a mapped register, which restarts
// the stream at the initial counter, the first byte waits for the first block.
// Configuration is to be written only while no request is in flight; the block does not check it.
module chacha20_stream_cipher_top import ccs_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  ccs_in_if.sink      in_if,
  ccs_out_if.source   out_if,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [255:0]       key_r, key_nxt;
  logic [95:0]        nonce_r, nonce_nxt;
  logic [31:0]        init_ctr_r, init_ctr_nxt;
  logic               restart;
  ksq_stat_t          q_stat;
  logic               push_en;
  logic [BLOCK_W-1:0] push_data;
  logic [BLOCK_W-1:0] head_data;
  logic               pop;

  // Register write decode; an unknown index changes nothing.
  always_comb begin
    key_nxt      = key_r;
    nonce_nxt    = nonce_r;
    init_ctr_nxt = init_ctr_r;
    restart      = 1'b0;
    if (cfg_we) begin
      restart = 1'b1;
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY_01:   key_nxt[63:0]    = cfg_wdata;
        REG_KEY_23:   key_nxt[127:64]  = cfg_wdata;
        REG_KEY_45:   key_nxt[191:128] = cfg_wdata;
        REG_KEY_67:   key_nxt[255:192] = cfg_wdata;
        REG_NONCE_01: nonce_nxt[63:0]  = cfg_wdata;
        REG_NONCE_2:  nonce_nxt[95:64] = cfg_wdata[31:0];
        REG_INIT_CTR: init_ctr_nxt     = cfg_wdata[31:0];
        default:      restart          = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r      <= '0;
      nonce_r    <= '0;
      init_ctr_r <= CTR_RESET;
    end else begin
      key_r      <= key_nxt;
      nonce_r    <= nonce_nxt;
      init_ctr_r <= init_ctr_nxt;
    end
  end

  ccs_keygen #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) u_keygen (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .ctr_load  (init_ctr_nxt),
    .key       (key_r),
    .nonce     (nonce_r),
    .q_stat    (q_stat),
    .push_en   (push_en),
    .push_data (push_data)
  );

  ccs_ksq u_ksq (
    .clk       (clk),
    .rst_n     (rst_n),
    .flush     (restart),
    .push_en   (push_en),
    .push_data (push_data),
    .pop       (pop),
    .q_stat    (q_stat),
    .head_data (head_data)
  );

  ccs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .restart   (restart),
    .q_stat    (q_stat),
    .head_data (head_data),
    .pop       (pop),
    .in_if     (in_if),
    .out_if    (out_if)
  );

endmodule

@@ design/ccs_checker.sv @@
// Port-level checks for the ChaCha20 stream cipher, bound to its top level.
module ccs_checker import ccs_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       cfg_we,
  input logic [2:0] cfg_index
);

  // A held result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before it was taken");

  // A held result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte))
    else $error("result changed while stalled");

  // Every accepted request shows a result on the next cycle.
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("accepted request produced no result");

  // A write to a mapped register restarts the stream, so no request can be taken right after it.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we && (cfg_index <= REG_INIT_CTR) |=> !in_ready)
    else $error("request path open right after a restart");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind chacha20_stream_cipher_top ccs_checker u_ccs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_byte  (out_if.out_byte),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index)
);

@@ sim/chacha20_stream_cipher_checker.sv @@
// Checker for the ChaCha20 stream cipher: keystream prediction and result comparison.
`timescale 1ns / 100ps

module chacha20_stream_cipher_checker import ccs_pkg::*; #(
  parameter int DOUBLE_ROUNDS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [7:0]  out_byte,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int unsigned outstanding,
  output int unsigned fail_count
);

  // Cipher settings and stream position as the block should hold them.
  logic [255:0] key_bits;
  logic [95:0]  nonce_bits;
  logic [31:0]  start_ctr;
  logic [31:0]  block_ctr;
  logic [5:0]   byte_pos;
  logic [511:0] keystream;
  logic [7:0]   expected_bytes[$];
  int unsigned  mismatches;

  function automatic logic [31:0] rotl32(input logic [31:0] v, input int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic logic [15:0][31:0] quarter_round(input logic [15:0][31:0] s,
                                                      input int a, input int b,
                                                      input int c, input int d);
    logic [15:0][31:0] x;
    x    = s;
    x[a] = x[a] + x[b];
    x[d] = rotl32(x[d] ^ x[a], 16);
    x[c] = x[c] + x[d];
    x[b] = rotl32(x[b] ^ x[c], 12);
    x[a] = x[a] + x[b];
    x[d] = rotl32(x[d] ^ x[a], 8);
    x[c] = x[c] + x[d];
    x[b] = rotl32(x[b] ^ x[c], 7);
    return x;
  endfunction

  // One 64-byte keystream block; byte p sits at bits [8p+7:8p].
  function automatic logic [511:0] chacha_block(input logic [255:0] k,
                                                input logic [95:0] n,
                                                input logic [31:0] ctr);
    logic [15:0][31:0] init_w;
    logic [15:0][31:0] x;
    logic [511:0]      blk;
    for (int i = 0; i < 4; i++) init_w[i] = SIGMA[i];
    for (int i = 0; i < 8; i++) init_w[4 + i] = k[32 * i +: 32];
    init_w[12] = ctr;
    for (int i = 0; i < 3; i++) init_w[13 + i] = n[32 * i +: 32];
    x = init_w;
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      x = quarter_round(x, 0, 4, 8, 12);
      x = quarter_round(x, 1, 5, 9, 13);
      x = quarter_round(x, 2, 6, 10, 14);
      x = quarter_round(x, 3, 7, 11, 15);
      x = quarter_round(x, 0, 5, 10, 15);
      x = quarter_round(x, 1, 6, 11, 12);
      x = quarter_round(x, 2, 7, 8, 13);
      x = quarter_round(x, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) blk[32 * i +: 32] = x[i] + init_w[i];
    return blk;
  endfunction

  always @(posedge clk) begin
    logic [7:0] want;
    logic       restart;
    if (!rst_n) begin
      key_bits   = '0;
      nonce_bits = '0;
      start_ctr  = CTR_RESET;
      block_ctr  = CTR_RESET;
      byte_pos   = '0;
      keystream  = '0;
      mismatches = 0;
      expected_bytes.delete();
    end else begin
      // A write to a mapped register restarts the stream at the start counter.
      if (cfg_we) begin
        restart = 1'b1;
        case (cfg_reg_t'(cfg_index))
          REG_KEY_01:   key_bits[63:0]    = cfg_wdata;
          REG_KEY_23:   key_bits[127:64]  = cfg_wdata;
          REG_KEY_45:   key_bits[191:128] = cfg_wdata;
          REG_KEY_67:   key_bits[255:192] = cfg_wdata;
          REG_NONCE_01: nonce_bits[63:0]  = cfg_wdata;
          REG_NONCE_2:  nonce_bits[95:64] = cfg_wdata[31:0];
          REG_INIT_CTR: start_ctr         = cfg_wdata[31:0];
          default:      restart           = 1'b0;
        endcase
        if (restart) begin
          block_ctr = start_ctr;
          byte_pos  = '0;
        end
      end

      // Each accepted request consumes the next keystream byte.
      if (in_valid && in_ready) begin
        if (byte_pos == 0) keystream = chacha_block(key_bits, nonce_bits, block_ctr);
        expected_bytes.push_back(in_data ^ keystream[8 * int'(byte_pos) +: 8]);
        byte_pos = byte_pos + 6'd1;
        if (byte_pos == 0) block_ctr = block_ctr + 32'd1;
      end

      // Results come back in request order.
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          $error("out_byte: expected no result, actual %02h", out_byte);
          mismatches++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want) begin
            $error("out_byte: expected %02h, actual %02h", want, out_byte);
            mismatches++;
          end
        end
      end
    end
    outstanding <= expected_bytes.size();
    fail_count  <= mismatches;
  end

endmodule

@@ sim/chacha20_stream_cipher_top_test.sv @@
// Testbench top for the ChaCha20 stream cipher: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module chacha20_stream_cipher_top_test;
  import ccs_pkg::*;

  localparam int          DOUBLE_ROUNDS = 10;
  localparam int          BLOCK_CYCLES  = 4 * DOUBLE_ROUNDS + 8;
  localparam int          RANDOM_BYTES  = 1750;
  localparam logic [2:0]  REG_UNMAPPED  = 3'd7;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;
  int unsigned outstanding;
  int unsigned fail_count;
  bit          src_idle_on;
  bit          snk_idle_on;
  int unsigned random_sent;

  ccs_in_if  in_ch();
  ccs_out_if out_ch();

  chacha20_stream_cipher_top #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  chacha20_stream_cipher_checker #(
    .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
  ) i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data_byte),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Give up well past the slowest legal run.
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: with sink idling on, drop ready for a random stall before taking each result.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge clk);
    forever begin
      stall = snk_idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one request, after a random gap when source idling is on, and hold it until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_byte(8'($urandom()));
    random_sent += count;
  endtask

  // Stop offering requests and wait until every result has come back.
  task automatic drain_stream(input int settle);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One register write per cycle; the caller lowers cfg_we after the last one.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic set_cipher(input logic [255:0] key, input logic [95:0] nonce,
                            input logic [31:0] ctr);
    write_reg(REG_KEY_01, key[63:0]);
    write_reg(REG_KEY_23, key[127:64]);
    write_reg(REG_KEY_45, key[191:128]);
    write_reg(REG_KEY_67, key[255:192]);
    write_reg(REG_NONCE_01, nonce[63:0]);
    write_reg(REG_NONCE_2, {$urandom(), nonce[95:64]});
    write_reg(REG_INIT_CTR, {$urandom(), ctr});
    cfg_we <= 1'b0;
  endtask

  task automatic pick_idling();
    int mode;
    mode        = $urandom_range(0, 3);
    src_idle_on = (mode == 0) || (mode == 2);
    snk_idle_on = (mode == 0) || (mode == 3);
  endtask

  // A random subset of registers, the start counter often near its extremes.
  task automatic random_config();
    bit          wrote;
    logic [63:0] val;
    wrote = 1'b0;
    for (int r = 0; r <= int'(REG_INIT_CTR); r++) begin
      if ($urandom_range(0, 1) == 1) begin
        val = rand64();
        if (cfg_reg_t'(r) == REG_INIT_CTR) begin
          case ($urandom_range(0, 3))
            0:       val[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 2);
            1:       val[31:0] = 32'h0;
            default: val[31:0] = $urandom();
          endcase
        end
        write_reg(3'(r), val);
        wrote = 1'b1;
      end
    end
    if (!wrote) write_reg(REG_INIT_CTR, rand64());
    if ($urandom_range(0, 7) == 0) write_reg(REG_UNMAPPED, rand64());
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned burst;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    cfg_we          = 1'b0;
    cfg_index       = REG_KEY_01;
    cfg_wdata       = '0;
    src_idle_on     = 1'b1;
    snk_idle_on     = 1'b1;
    random_sent     = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: byte extremes, walking ones and walking zeros.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h55);
    send_byte(8'hAA);
    for (int i = 0; i < 8; i++) send_byte(8'h01 << i);
    for (int i = 0; i < 8; i++) send_byte(~(8'h01 << i));
    drain_stream(2);

    // An unmapped index must not restart the stream; carry on past the block edge.
    write_reg(REG_UNMAPPED, rand64());
    cfg_we <= 1'b0;
    send_random(70);
    drain_stream(2);

    // All-ones key and nonce with the counter wrapping from its top value.
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    set_cipher('1, '1, 32'hFFFF_FFFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_random(140);
    drain_stream(2);

    // All-zero key, nonce and counter, then a restart in the middle of a block.
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    set_cipher('0, '0, 32'h0);
    send_random(70);
    drain_stream(2);
    write_reg(REG_INIT_CTR, {32'hFFFF_FFFF, 32'hFFFF_FFFE});
    cfg_we <= 1'b0;
    send_random(100);
    drain_stream(2);

    // Random settings and stream lengths, with an occasional full pause mid-stream.
    while (random_sent < RANDOM_BYTES) begin
      random_config();
      pick_idling();
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 5) : $urandom_range(20, 300);
      if ($urandom_range(0, 3) == 0) begin
        send_random(burst / 2);
        drain_stream(0);
        pick_idling();
        send_random(burst - burst / 2);
      end else begin
        send_random(burst);
      end
      drain_stream(2);
    end

    drain_stream(BLOCK_CYCLES);
    if (fail_count == 0 && outstanding == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
